### design/yrm_pkg.sv
// shared types and constants for the yuyv to rgb converter with motion detection
// no dependencies; compile first
package yrm_pkg;

   localparam int PIX_W      = 8;
   localparam int CNT_W      = 20;
   localparam int WORD_W     = 4 * PIX_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int DEF_MAX_PIXEL_PAIRS = 262144;
   localparam int DEF_COEF_FRAC_BITS  = 16;

   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_THR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_THR  = 2'd2;

   localparam logic [PIX_W-1:0] RST_LUMA_THR   = 8'd32;
   localparam logic [PIX_W-1:0] RST_CHROMA_THR = 8'd32;
   localparam logic [CNT_W-1:0] RST_COUNT_THR  = 20'd1024;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] chroma;
      logic [CNT_W-1:0] count;
   } thr_type;

   // classified macropixel handed from the front end to the back end
   typedef struct packed {
      logic [PIX_W-1:0] luma_even;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_odd;
      logic [PIX_W-1:0] chroma_red;
      logic             changed_even;
      logic             changed_odd;
      logic [CNT_W-1:0] count_even;
      logic [CNT_W-1:0] count_odd;
      logic             motion;
      logic             last;
   } pair_type;

endpackage

### design/yrm_if.sv
// channel interfaces: macropixel input, rgb pixel output, register write port
// depends on yrm_pkg
interface yrm_req_if;
   import yrm_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma_even;
   logic [PIX_W-1:0] chroma_blue;
   logic [PIX_W-1:0] luma_odd;
   logic [PIX_W-1:0] chroma_red;
   logic             last_pair_in_frame;

   modport source (
      output valid, luma_even, chroma_blue, luma_odd, chroma_red, last_pair_in_frame,
      input  ready
   );
   modport sink (
      input  valid, luma_even, chroma_blue, luma_odd, chroma_red, last_pair_in_frame,
      output ready
   );
endinterface

interface yrm_rsp_if;
   import yrm_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             pixel_changed;
   logic [CNT_W-1:0] running_changed;
   logic             motion_detected;
   logic             frame_done;
   logic             second_of_pair;

   modport source (
      output valid, red, green, blue, pixel_changed, running_changed, motion_detected,
             frame_done, second_of_pair,
      input  ready
   );
   modport sink (
      input  valid, red, green, blue, pixel_changed, running_changed, motion_detected,
             frame_done, second_of_pair,
      output ready
   );
endinterface

interface yrm_csr_if;
   import yrm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/yrm_front.sv
// front end: accepts macropixels, reads the reference store, classifies change,
// keeps the per-frame changed count; depends on yrm_pkg and yrm_if
module yrm_front #(
   parameter int MAX_PIXEL_PAIRS = yrm_pkg::DEF_MAX_PIXEL_PAIRS
) (
   input  logic              clock,
   input  logic              reset,
   yrm_req_if.sink           req_chan,
   input  yrm_pkg::thr_type  thr,
   output logic              push_valid,
   input  logic              push_ready,
   output yrm_pkg::pair_type push_data
);
   import yrm_pkg::*;

   localparam int ADDR_W = (MAX_PIXEL_PAIRS > 1) ? $clog2(MAX_PIXEL_PAIRS) : 1;
   localparam logic [ADDR_W:0] DEPTH = (ADDR_W + 1)'(MAX_PIXEL_PAIRS);

   typedef struct packed {
      logic [PIX_W-1:0] y0;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] y1;
      logic [PIX_W-1:0] cr;
      logic             last;
   } item_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] res;
      if (a >= b) begin
         res = a - b;
      end else begin
         res = b - a;
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt,
                                                input logic             inc);
      logic [CNT_W-1:0] res;
      if (inc && (cnt != '1)) begin
         res = cnt + 1'b1;
      end else begin
         res = cnt;
      end
      return res;
   endfunction

   logic [WORD_W-1:0] ref_mem [MAX_PIXEL_PAIRS];

   logic              f1_v_ff, f1_v_in;
   item_type          f1_item_ff;
   logic [ADDR_W-1:0] f1_addr_ff;
   logic              f1_byp_ff;
   logic              f1_seen_ff;
   logic [WORD_W-1:0] f1_byp_word_ff;
   logic [WORD_W-1:0] rd_word_ff;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              accept;
   logic              f1_go;
   logic [ADDR_W:0]   addr_inc;
   logic [WORD_W-1:0] old_word;
   logic [WORD_W-1:0] new_word;
   logic              ch0, ch1;
   logic [CNT_W-1:0]  cnt0, cnt1;
   logic [PIX_W-1:0]  ref_y0, ref_cb, ref_y1, ref_cr;

   assign f1_go          = f1_v_ff && push_ready;
   assign req_chan.ready = !f1_v_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign addr_inc = {1'b0, addr_ff} + 1'b1;

   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         if (req_chan.last_pair_in_frame || (addr_inc >= DEPTH)) begin
            addr_in = '0;
         end else begin
            addr_in = addr_inc[ADDR_W-1:0];
         end
      end
   end

   assign f1_v_in = accept || (f1_v_ff && !push_ready);

   // reference store: one write port (retire), one registered read port (accept)
   always_ff @(posedge clock) begin
      if (f1_go) begin
         ref_mem[f1_addr_ff] <= new_word;
      end
      if (accept) begin
         rd_word_ff     <= ref_mem[addr_ff];
         f1_item_ff     <= '{y0: req_chan.luma_even, cb: req_chan.chroma_blue,
                             y1: req_chan.luma_odd, cr: req_chan.chroma_red,
                             last: req_chan.last_pair_in_frame};
         f1_addr_ff     <= addr_ff;
         // read and write of the same entry in one cycle: forward the new word
         f1_byp_ff      <= f1_go && (f1_addr_ff == addr_ff);
         f1_byp_word_ff <= new_word;
         // entries at or beyond the fill mark were never written and read as zero
         f1_seen_ff     <= {1'b0, addr_ff} < fill_ff;
      end
   end

   always_comb begin
      if (f1_byp_ff) begin
         old_word = f1_byp_word_ff;
      end else if (f1_seen_ff) begin
         old_word = rd_word_ff;
      end else begin
         old_word = '0;
      end
   end

   assign {ref_cr, ref_y1, ref_cb, ref_y0} = old_word;
   assign new_word = {f1_item_ff.cr, f1_item_ff.y1, f1_item_ff.cb, f1_item_ff.y0};

   assign ch0 = (abs_diff(f1_item_ff.y0, ref_y0) >= thr.luma) ||
                (abs_diff(f1_item_ff.cb, ref_cb) >= thr.chroma) ||
                (abs_diff(f1_item_ff.cr, ref_cr) >= thr.chroma);
   assign ch1 = (abs_diff(f1_item_ff.y1, ref_y1) >= thr.luma) ||
                (abs_diff(f1_item_ff.cb, ref_cb) >= thr.chroma) ||
                (abs_diff(f1_item_ff.cr, ref_cr) >= thr.chroma);

   assign cnt0 = sat_inc(cnt_ff, ch0);
   assign cnt1 = sat_inc(cnt0, ch1);

   always_comb begin
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      if (f1_go) begin
         cnt_in = f1_item_ff.last ? '0 : cnt1;
         // frames always restart at entry zero, so the written entries form a prefix
         if (({1'b0, f1_addr_ff} == fill_ff) && (fill_ff < DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         addr_ff <= '0;
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         f1_v_ff <= f1_v_in;
         addr_ff <= addr_in;
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign push_valid = f1_v_ff;
   assign push_data  = '{luma_even: f1_item_ff.y0, chroma_blue: f1_item_ff.cb,
                         luma_odd: f1_item_ff.y1, chroma_red: f1_item_ff.cr,
                         changed_even: ch0, changed_odd: ch1,
                         count_even: cnt0, count_odd: cnt1,
                         motion: f1_item_ff.last && (cnt1 >= thr.count),
                         last: f1_item_ff.last};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH)
      else $error("fill mark beyond store depth");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      f1_go && f1_item_ff.last |=> (cnt_ff == '0))
      else $error("changed count not cleared at frame end");

endmodule

### design/yrm_queue.sv
// short queue between front and back end
// depends on yrm_pkg
module yrm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  yrm_pkg::pair_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output yrm_pkg::pair_type pop_data
);
   import yrm_pkg::*;

   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam logic [QUEUE_AW:0]   FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] LAST = QUEUE_AW'(QUEUE_DEPTH - 1);

   pair_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                push_fire, pop_fire;

   assign push_ready = cnt_ff != FULL;
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue occupancy lost a transaction");

endmodule

### design/yrm_back.sv
// back end: splits a pair into two pixels, converts ycbcr to rgb in fixed point,
// holds the result register; depends on yrm_pkg and yrm_if
module yrm_back #(
   parameter int COEF_FRAC_BITS = yrm_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  yrm_pkg::pair_type pop_data,
   yrm_rsp_if.source         rsp_chan
);
   import yrm_pkg::*;

   localparam int ACC_W = COEF_FRAC_BITS + 12;

   localparam longint K_R_VAL  = ((longint'(1402000) << COEF_FRAC_BITS) + 500000) / 1000000;
   localparam longint K_GB_VAL = ((longint'(344140) << COEF_FRAC_BITS) + 500000) / 1000000;
   localparam longint K_GR_VAL = ((longint'(714140) << COEF_FRAC_BITS) + 500000) / 1000000;
   localparam longint K_B_VAL  = ((longint'(1772000) << COEF_FRAC_BITS) + 500000) / 1000000;

   localparam logic signed [ACC_W-1:0] K_R  = ACC_W'(K_R_VAL);
   localparam logic signed [ACC_W-1:0] K_GB = ACC_W'(K_GB_VAL);
   localparam logic signed [ACC_W-1:0] K_GR = ACC_W'(K_GR_VAL);
   localparam logic signed [ACC_W-1:0] K_B  = ACC_W'(K_B_VAL);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(255) << COEF_FRAC_BITS;

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [ACC_W-1:0] acc);
      logic [PIX_W-1:0] res;
      if (acc <= 0) begin
         res = '0;
      end else if (acc >= ACC_MAX) begin
         res = '1;
      end else begin
         res = acc[COEF_FRAC_BITS +: PIX_W];
      end
      return res;
   endfunction

   logic phase_ff, phase_in;

   // multiply stage
   logic                    m_v_ff, m_v_in;
   logic [PIX_W-1:0]        m_y_ff;
   logic signed [ACC_W-1:0] m_pr_ff, m_pgb_ff, m_pgr_ff, m_pb_ff;
   logic                    m_changed_ff;
   logic [CNT_W-1:0]        m_count_ff;
   logic                    m_motion_ff;
   logic                    m_done_ff;
   logic                    m_second_ff;

   // result register
   logic             o_v_ff, o_v_in;
   logic [PIX_W-1:0] o_red_ff, o_green_ff, o_blue_ff;
   logic             o_changed_ff;
   logic [CNT_W-1:0] o_count_ff;
   logic             o_motion_ff;
   logic             o_done_ff;
   logic             o_second_ff;

   logic                    o_adv, m_adv, m_load;
   logic signed [8:0]       u_s, v_s;
   logic signed [ACC_W-1:0] u_ext, v_ext, y_acc;

   assign o_adv     = !o_v_ff || rsp_chan.ready;
   assign m_adv     = !m_v_ff || o_adv;
   assign m_load    = m_adv && pop_valid;
   // the pair leaves the queue when its second pixel enters the multiply stage
   assign pop_ready = m_load && phase_ff;

   assign phase_in = m_load ? !phase_ff : phase_ff;
   assign m_v_in   = m_load || (m_v_ff && !o_adv);
   assign o_v_in   = (m_v_ff && o_adv) || (o_v_ff && !rsp_chan.ready);

   assign u_s   = $signed({1'b0, pop_data.chroma_blue}) - 9'sd128;
   assign v_s   = $signed({1'b0, pop_data.chroma_red}) - 9'sd128;
   assign u_ext = ACC_W'(u_s);
   assign v_ext = ACC_W'(v_s);
   assign y_acc = $signed(ACC_W'(m_y_ff)) <<< COEF_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_y_ff       <= phase_ff ? pop_data.luma_odd : pop_data.luma_even;
         m_pr_ff      <= K_R * v_ext;
         m_pgb_ff     <= K_GB * u_ext;
         m_pgr_ff     <= K_GR * v_ext;
         m_pb_ff      <= K_B * u_ext;
         m_changed_ff <= phase_ff ? pop_data.changed_odd : pop_data.changed_even;
         m_count_ff   <= phase_ff ? pop_data.count_odd : pop_data.count_even;
         m_motion_ff  <= phase_ff && pop_data.motion;
         m_done_ff    <= phase_ff && pop_data.last;
         m_second_ff  <= phase_ff;
      end
      if (m_v_ff && o_adv) begin
         o_red_ff     <= clamp_pix(y_acc + m_pr_ff);
         o_green_ff   <= clamp_pix(y_acc - m_pgb_ff - m_pgr_ff);
         o_blue_ff    <= clamp_pix(y_acc + m_pb_ff);
         o_changed_ff <= m_changed_ff;
         o_count_ff   <= m_count_ff;
         o_motion_ff  <= m_motion_ff;
         o_done_ff    <= m_done_ff;
         o_second_ff  <= m_second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         m_v_ff   <= 1'b0;
         o_v_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         m_v_ff   <= m_v_in;
         o_v_ff   <= o_v_in;
      end
   end

   assign rsp_chan.valid           = o_v_ff;
   assign rsp_chan.red             = o_red_ff;
   assign rsp_chan.green           = o_green_ff;
   assign rsp_chan.blue            = o_blue_ff;
   assign rsp_chan.pixel_changed   = o_changed_ff;
   assign rsp_chan.running_changed = o_count_ff;
   assign rsp_chan.motion_detected = o_motion_ff;
   assign rsp_chan.frame_done      = o_done_ff;
   assign rsp_chan.second_of_pair  = o_second_ff;

   a_first_pixel_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.second_of_pair |->
         !rsp_chan.frame_done && !rsp_chan.motion_detected)
      else $error("frame flags on first pixel of a pair");

   a_pop_phase: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> !phase_ff)
      else $error("pixel phase out of step with queue");

endmodule

### design/yuyv_to_rgb_motion_detect_core.sv
// top level: threshold registers, front end, queue and back end
// depends on yrm_pkg, yrm_if, yrm_front, yrm_queue, yrm_back
//
//   channel   dir  modport  payload
//   req_chan  in   sink     luma_even, chroma_blue, luma_odd, chroma_red, last_pair_in_frame
//   rsp_chan  out  source   red, green, blue, pixel_changed, running_changed,
//                           motion_detected, frame_done, second_of_pair
//   csr_chan  in   sink     index, data (always ready)
//
// one macropixel in, two pixel transactions out, first pixel then second
// sustained macropixel rate is set by the back end, which drives one pixel per cycle while
// rsp_chan is ready; the front end takes a transaction every cycle until the queue fills;
// a pair passes the front-end register, a queue slot, the multiply stage and the result register
// synchronous reset clears control state and the reference store's fill mark, so
// entries not yet written read as zero with no clearing pass
// either side may stall at any time; the queue decouples front and back end
module yuyv_to_rgb_motion_detect_core #(
   parameter int MAX_PIXEL_PAIRS = yrm_pkg::DEF_MAX_PIXEL_PAIRS,
   parameter int COEF_FRAC_BITS  = yrm_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   yrm_req_if.sink   req_chan,
   yrm_rsp_if.source rsp_chan,
   yrm_csr_if.sink   csr_chan
);
   import yrm_pkg::*;

   thr_type  thr_ff, thr_in;
   logic     push_valid, push_ready;
   pair_type push_data;
   logic     pop_valid, pop_ready;
   pair_type pop_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_LUMA_THR:   thr_in.luma   = csr_chan.data[PIX_W-1:0];
            CSR_CHROMA_THR: thr_in.chroma = csr_chan.data[PIX_W-1:0];
            CSR_COUNT_THR:  thr_in.count  = csr_chan.data[CNT_W-1:0];
            default:        thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '{luma: RST_LUMA_THR, chroma: RST_CHROMA_THR, count: RST_COUNT_THR};
      end else begin
         thr_ff <= thr_in;
      end
   end

   yrm_front #(
      .MAX_PIXEL_PAIRS(MAX_PIXEL_PAIRS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .thr       (thr_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   yrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   yrm_back #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/sv/yuyv_to_rgb_motion_detect_core_test.sv
// testbench for yuyv_to_rgb_motion_detect_core: yuyv pairs in, rgb pixels out, checked
// against an in-bench predictor of color conversion and frame-difference motion detection
// depends on yrm_pkg, yrm_if and the core
module yuyv_to_rgb_motion_detect_core_test;
   import yrm_pkg::*;

   localparam int FRAC = DEF_COEF_FRAC_BITS;
   localparam longint K_RED     = ((longint'(1402000) << FRAC) + 500000) / 1000000;
   localparam longint K_GREEN_B = ((longint'(344140) << FRAC) + 500000) / 1000000;
   localparam longint K_GREEN_R = ((longint'(714140) << FRAC) + 500000) / 1000000;
   localparam longint K_BLUE    = ((longint'(1772000) << FRAC) + 500000) / 1000000;
   localparam longint SAT_LEVEL = longint'(255) << FRAC;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT      = 5000;

   typedef struct packed {
      logic [PIX_W-1:0] luma_even;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_odd;
      logic [PIX_W-1:0] chroma_red;
      logic             last;
   } macropixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             pixel_changed;
      logic [CNT_W-1:0] running_changed;
      logic             motion_detected;
      logic             frame_done;
      logic             second_of_pair;
   } rgb_pixel_type;

   logic clock = 1'b0;
   logic reset;

   yrm_req_if req_chan ();
   yrm_rsp_if rsp_chan ();
   yrm_csr_if csr_chan ();

   yuyv_to_rgb_motion_detect_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted state of the block
   bit   [WORD_W-1:0] ref_store [DEF_MAX_PIXEL_PAIRS];
   int                pair_addr   = 0;
   logic [CNT_W-1:0]  changed_cnt = '0;
   logic [PIX_W-1:0]  luma_thr    = RST_LUMA_THR;
   logic [PIX_W-1:0]  chroma_thr  = RST_CHROMA_THR;
   logic [CNT_W-1:0]  count_thr   = RST_COUNT_THR;

   rgb_pixel_type pending_pixels [$];
   int failures      = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;

   function automatic logic [PIX_W-1:0] clamp_channel(input longint acc);
      if (acc <= 0) return '0;
      if (acc >= SAT_LEVEL) return '1;
      return PIX_W'(acc >>> FRAC);
   endfunction

   function automatic logic [PIX_W-1:0] abs_delta(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic predict_pixel_pair(input macropixel_type m);
      logic [WORD_W-1:0] stored;
      logic [PIX_W-1:0]  y;
      logic [PIX_W-1:0]  ry;
      rgb_pixel_type     px;
      longint            luma_q;
      longint            u;
      longint            v;
      stored = ref_store[pair_addr];
      u = longint'(m.chroma_blue) - 128;
      v = longint'(m.chroma_red) - 128;
      for (int half = 0; half < 2; half++) begin
         y  = (half == 1) ? m.luma_odd : m.luma_even;
         ry = (half == 1) ? stored[23:16] : stored[7:0];
         // both pixels compare against the stored chroma of the old pair
         px.pixel_changed = abs_delta(y, ry) >= luma_thr ||
                            abs_delta(m.chroma_blue, stored[15:8]) >= chroma_thr ||
                            abs_delta(m.chroma_red, stored[31:24]) >= chroma_thr;
         luma_q = longint'(y) << FRAC;
         px.red   = clamp_channel(luma_q + K_RED * v);
         px.green = clamp_channel(luma_q - K_GREEN_B * u - K_GREEN_R * v);
         px.blue  = clamp_channel(luma_q + K_BLUE * u);
         if (px.pixel_changed && changed_cnt != '1) changed_cnt++;
         px.running_changed = changed_cnt;
         px.second_of_pair  = (half == 1);
         px.frame_done      = px.second_of_pair && m.last;
         px.motion_detected = px.frame_done && (changed_cnt >= count_thr);
         pending_pixels.push_back(px);
      end
      ref_store[pair_addr] = {m.chroma_red, m.luma_odd, m.chroma_blue, m.luma_even};
      if (m.last) begin
         pair_addr   = 0;
         changed_cnt = '0;
      end else begin
         pair_addr = (pair_addr + 1 == DEF_MAX_PIXEL_PAIRS) ? 0 : pair_addr + 1;
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t ERROR %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // monitor: register shadow, prediction on input transactions, check on output ones
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_LUMA_THR:   luma_thr   = csr_chan.data[PIX_W-1:0];
               CSR_CHROMA_THR: chroma_thr = csr_chan.data[PIX_W-1:0];
               CSR_COUNT_THR:  count_thr  = csr_chan.data;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_pixels.size() == 0) begin
               failures++;
               $display("%0t ERROR pixel transaction with nothing pending", $time);
            end else begin
               want = pending_pixels.pop_front();
               check_field("red", 32'(want.red), 32'(rsp_chan.red));
               check_field("green", 32'(want.green), 32'(rsp_chan.green));
               check_field("blue", 32'(want.blue), 32'(rsp_chan.blue));
               check_field("pixel_changed", 32'(want.pixel_changed),
                           32'(rsp_chan.pixel_changed));
               check_field("running_changed", 32'(want.running_changed),
                           32'(rsp_chan.running_changed));
               check_field("motion_detected", 32'(want.motion_detected),
                           32'(rsp_chan.motion_detected));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_chan.frame_done));
               check_field("second_of_pair", 32'(want.second_of_pair),
                           32'(rsp_chan.second_of_pair));
            end
         end
         if (req_chan.valid && req_chan.ready)
            predict_pixel_pair('{req_chan.luma_even, req_chan.chroma_blue, req_chan.luma_odd,
                                 req_chan.chroma_red, req_chan.last_pair_in_frame});
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ERROR no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // output ready: random stalls, or a long hold-off on request
   initial begin : rsp_ready_driver
      int held;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            held = hold_request;
            hold_request = 0;
            repeat (held) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // valid stays high from one transaction to the next unless an idle gap is drawn
   task automatic send_pair(input macropixel_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.luma_even          <= m.luma_even;
      req_chan.chroma_blue        <= m.chroma_blue;
      req_chan.luma_odd           <= m.luma_odd;
      req_chan.chroma_red         <= m.chroma_red;
      req_chan.last_pair_in_frame <= m.last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic set_thresholds(input logic [PIX_W-1:0] luma, input logic [PIX_W-1:0] chroma,
                                 input logic [CNT_W-1:0] count, input bit poke_unused = 1'b0);
      logic [CSR_IDX_W-1:0]  idx [$];
      logic [CSR_DATA_W-1:0] val [$];
      idx = '{CSR_LUMA_THR, CSR_CHROMA_THR, CSR_COUNT_THR};
      val = '{CSR_DATA_W'(luma), CSR_DATA_W'(chroma), CSR_DATA_W'(count)};
      // a write to the unused index must leave every threshold alone
      if (poke_unused) begin
         idx.push_back(CSR_UNUSED);
         val.push_back('1);
      end
      foreach (idx[i]) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[i];
         csr_chan.data  <= val[i];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   function automatic macropixel_type random_macropixel(input bit last);
      return {$urandom(), last};
   endfunction

   function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] v);
      return ($urandom_range(1) == 1) ? v ^ PIX_W'($urandom_range(63)) : v;
   endfunction

   task automatic test_color_extremes();
      macropixel_type corners [8] = '{
         '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
         '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0},
         '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0},
         '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0},
         '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0},
         '{8'd16,  8'd128, 8'd235, 8'd128, 1'b0},
         '{8'd81,  8'd90,  8'd145, 8'd240, 1'b0},
         '{8'd41,  8'd240, 8'd210, 8'd110, 1'b1}
      };
      foreach (corners[i]) send_pair(corners[i]);
   endtask

   // differences exactly at and one below each threshold, count reached and missed by one
   task automatic test_change_thresholds();
      macropixel_type frames [9] = '{
         '{8'd100, 8'd100, 8'd100, 8'd100, 1'b0},
         '{8'd50,  8'd60,  8'd70,  8'd80,  1'b0},
         '{8'd200, 8'd200, 8'd200, 8'd200, 1'b1},
         '{8'd110, 8'd100, 8'd91,  8'd100, 1'b0},
         '{8'd50,  8'd80,  8'd70,  8'd80,  1'b0},
         '{8'd200, 8'd200, 8'd200, 8'd219, 1'b1},
         '{8'd110, 8'd100, 8'd91,  8'd100, 1'b0},
         '{8'd50,  8'd80,  8'd70,  8'd80,  1'b0},
         '{8'd190, 8'd200, 8'd210, 8'd219, 1'b1}
      };
      wait_for_results();
      set_thresholds(8'd10, 8'd20, 20'd3, 1'b1);
      foreach (frames[i]) send_pair(frames[i]);
   endtask

   task automatic test_threshold_extremes();
      wait_for_results();
      // a frame with no change still reports motion when the count threshold is zero
      set_thresholds('1, '1, '0);
      send_pair('{8'd0, 8'd0, 8'd255, 8'd255, 1'b1});
      send_pair('{8'd255, 8'd255, 8'd0, 8'd0, 1'b1});
      wait_for_results();
      set_thresholds('0, '0, '1);
      send_pair('{8'd255, 8'd255, 8'd0, 8'd0, 1'b1});
   endtask

   task automatic test_backpressure();
      wait_for_results();
      set_thresholds(8'd24, 8'd24, 20'd20);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 400;
      for (int n = 0; n < 30; n++) send_pair(random_macropixel(n == 29));
   endtask

   // mostly frames that revisit the stored content with small changes, some pure noise
   task automatic run_random_frames(input int n_items, input int idle_pct, input int stall);
      int             frame_len;
      int             pos;
      bit             last;
      macropixel_type m;
      logic [WORD_W-1:0] prior;
      wait_for_results();
      frame_len = $urandom_range(2, 40);
      set_thresholds(PIX_W'($urandom_range(1, 48)), PIX_W'($urandom_range(1, 48)),
                     CNT_W'($urandom_range(0, 2 * frame_len)));
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      pos = 0;
      for (int n = 0; n < n_items; n++) begin
         last = (pos == frame_len - 1) || (n == n_items - 1);
         m = random_macropixel(last);
         if ($urandom_range(3) != 0) begin
            prior = ref_store[pos];
            m.luma_even   = nudge(prior[7:0]);
            m.chroma_blue = nudge(prior[15:8]);
            m.luma_odd    = nudge(prior[23:16]);
            m.chroma_red  = nudge(prior[31:24]);
         end
         send_pair(m);
         pos++;
         if (last) begin
            pos = 0;
            if ($urandom_range(5) == 0) frame_len = $urandom_range(1, 48);
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      reset                       <= 1'b1;
      req_chan.valid              <= 1'b0;
      req_chan.luma_even          <= '0;
      req_chan.chroma_blue        <= '0;
      req_chan.luma_odd           <= '0;
      req_chan.chroma_red         <= '0;
      req_chan.last_pair_in_frame <= 1'b0;
      csr_chan.valid              <= 1'b0;
      csr_chan.index              <= CSR_LUMA_THR;
      csr_chan.data               <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_color_extremes();
      test_change_thresholds();
      test_threshold_extremes();
      test_backpressure();
      run_random_frames(150, 0, 0);
      run_random_frames(150, 80, 0);
      run_random_frames(150, 0, 80);
      run_random_frames(150, 21, 21);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### yuyv_to_rgb_motion_detect_core.f
design/yrm_pkg.sv
design/yrm_if.sv
design/yrm_front.sv
design/yrm_queue.sv
design/yrm_back.sv
design/yuyv_to_rgb_motion_detect_core.sv
tb/sv/yuyv_to_rgb_motion_detect_core_test.sv
